// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion lbl failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion lbl failed");

`endif

// ----- src/imusbc_pkg.sv -----
// ----------------------------------------------------------------------------
// imusbc_pkg
// types and constants of the imu static bias calibrator
// ----------------------------------------------------------------------------
package imusbc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;
    localparam int SUM_W     = 48;
    localparam int DIV_STEPS = 49;
    localparam int DVD_W     = 49;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 3'd4;

    // multiplier operation sequence
    localparam logic [4:0] OP_QSQ0     = 5'd0;
    localparam logic [4:0] OP_QSQ_LAST = 5'd3;
    localparam logic [4:0] OP_GYSQ0    = 5'd4;
    localparam logic [4:0] OP_GYSQ2    = 5'd6;
    localparam logic [4:0] OP_LIMSQ    = 5'd7;
    localparam logic [4:0] OP_ACSQ0    = 5'd8;
    localparam logic [4:0] OP_ACSQ2    = 5'd10;
    localparam logic [4:0] OP_LOWSQ    = 5'd11;
    localparam logic [4:0] OP_HIGHSQ   = 5'd12;
    localparam logic [4:0] OP_XZ       = 5'd13;
    localparam logic [4:0] OP_WY       = 5'd14;
    localparam logic [4:0] OP_YZ       = 5'd15;
    localparam logic [4:0] OP_WX       = 5'd16;
    localparam logic [4:0] OP_XX       = 5'd17;
    localparam logic [4:0] OP_YY       = 5'd18;
    localparam logic [4:0] OP_GT0      = 5'd19;
    localparam logic [4:0] OP_GT2      = 5'd21;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_QCHK,
        ST_SQRT,
        ST_QDIV,
        ST_STILL_CHK,
        ST_SUM,
        ST_COUNT,
        ST_BIAS,
        ST_EMIT
    } state_t;

endpackage

// ----- src/imu_static_bias_calibrator.sv -----
// ----------------------------------------------------------------------------
// imu static bias calibrator
// normalizes the attitude quaternion, averages still samples into gyro and
// accel biases, then streams decimated bias-corrected samples
// ----------------------------------------------------------------------------
//  channel   dir  handshake            contents
//  s_axis    in   tvalid/tready        one imu sample
//  m_axis    out  tvalid/tready        normalized attitude, corrected rates and accels
//  cfg       in   cfg_we               register write, no read-back
//
//  one shared 32x32 multiplier, a 2-bit-per-cycle square root and a 49-step
//  restoring divider under one sequencer; a sample with a too-small quaternion
//  is dropped after the norm check and, while calibrating, a non-still one after
//  the still check; an output slot may wait for the output register, a skipped
//  slot is consumed unprocessed; the completing sample adds six 49-step bias divisions
//  s_axis_tready is high only while the sequencer is idle
//  reset: asynchronous rst_n clears state, sums and biases and presets the config registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_static_bias_calibrator #(
    parameter int DECIMATION = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
    input  logic [255:0]                          s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z, lin_acc_x, lin_acc_y, lin_acc_z
    output logic [255:0]                          m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [imusbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imusbc_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [PHASE_W:0] DEC_C = (PHASE_W+1)'(DECIMATION);
    localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;
    localparam int DVD_W_L = imusbc_pkg::DVD_W;

    imusbc_pkg::state_t state_reg, state_next;

    logic signed [15:0] q_reg   [4];
    logic signed [31:0] gy_reg  [3];
    logic signed [31:0] ac_reg  [3];
    logic signed [15:0] q_next  [4];
    logic signed [31:0] gy_next [3];
    logic signed [31:0] ac_next [3];

    logic [30:0] grav_reg, lim_reg, low_reg, high_reg;
    logic [30:0] grav_next, lim_next, low_next, high_next;
    logic [15:0] samples_reg, samples_next;

    logic               calibrated_reg, calibrated_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0]        count_reg, count_next;
    logic signed [47:0] sum_reg  [6];
    logic signed [47:0] sum_next [6];
    logic signed [31:0] bias_reg  [6];
    logic signed [31:0] bias_next [6];

    logic [4:0]         op_reg, op_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next, an_reg, an_next;
    logic [61:0]        limsq_reg, limsq_next, lowsq_reg, lowsq_next;
    logic [61:0]        highsq_reg, highsq_next;

    logic [63:0] x_reg, x_next, r_reg, r_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic [30:0] n_reg, n_next;

    logic [30:0]       rem_reg, rem_next;
    logic [DVD_W_L-1:0] dvd_reg, dvd_next;
    logic [5:0]        div_cnt_reg, div_cnt_next;
    logic [2:0]        idx_reg, idx_next;

    logic signed [17:0] a_reg  [4];
    logic signed [17:0] a_next [4];
    logic signed [35:0] t_reg  [3];
    logic signed [35:0] t_next [3];
    logic signed [35:0] e_reg  [3];
    logic signed [35:0] e_next [3];

    logic [255:0] out_data_reg, out_data_next;
    logic         out_valid_reg, out_valid_next;

    // shared datapath signals
    logic signed [31:0] mul_x, mul_y;
    logic [PHASE_W:0]   phase_inc;
    logic               phase_skip, q_small, still_fail, sq_last, div_last;
    logic [15:0]        count_inc;
    logic               count_short;
    logic [30:0]        div_d;
    logic [31:0]        div_trial;
    logic               div_ge;
    logic [DVD_W_L-1:0] quo_final;
    logic [63:0]        sq_bit, sq_tr;
    logic               sq_ge;

    assign phase_inc   = {1'b0, phase_reg} + 1'b1;
    assign phase_skip  = calibrated_reg && (phase_inc < DEC_C);
    assign q_small     = acc_reg < 64'd67108864;
    assign still_fail  = (acc_reg > {2'b00, limsq_reg}) || (an_reg <= {2'b00, lowsq_reg})
                         || (an_reg >= {2'b00, highsq_reg});
    assign sq_last     = sq_cnt_reg == 5'd0;
    assign div_last    = div_cnt_reg == 6'(imusbc_pkg::DIV_STEPS - 1);
    assign count_inc   = count_reg + 16'd1;
    assign count_short = count_inc < samples_reg;

    assign div_d     = (state_reg == imusbc_pkg::ST_QDIV) ? n_reg : {15'd0, count_reg};
    assign div_trial = {rem_reg, dvd_reg[DVD_W_L-1]};
    assign div_ge    = div_trial >= {1'b0, div_d};
    assign quo_final = {dvd_reg[DVD_W_L-2:0], div_ge};

    assign sq_bit = 64'd1 << {sq_cnt_reg, 1'b0};
    assign sq_tr  = r_reg + sq_bit;
    assign sq_ge  = x_reg >= sq_tr;

    assign s_axis_tready = state_reg == imusbc_pkg::ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // shared multiplier operand select
    always_comb
    begin
        logic [1:0] k;
        k     = 2'd0;
        mul_x = 32'sd0;
        mul_y = 32'sd0;
        case (op_reg) inside
            [imusbc_pkg::OP_QSQ0:imusbc_pkg::OP_QSQ_LAST]:
            begin
                k     = op_reg[1:0];
                mul_x = 32'(q_reg[k]);
                mul_y = 32'(q_reg[k]);
            end
            [imusbc_pkg::OP_GYSQ0:imusbc_pkg::OP_GYSQ2]:
            begin
                k     = 2'(op_reg - imusbc_pkg::OP_GYSQ0);
                mul_x = gy_reg[k];
                mul_y = gy_reg[k];
            end
            imusbc_pkg::OP_LIMSQ:
            begin
                mul_x = $signed({1'b0, lim_reg});
                mul_y = $signed({1'b0, lim_reg});
            end
            [imusbc_pkg::OP_ACSQ0:imusbc_pkg::OP_ACSQ2]:
            begin
                k     = 2'(op_reg - imusbc_pkg::OP_ACSQ0);
                mul_x = ac_reg[k];
                mul_y = ac_reg[k];
            end
            imusbc_pkg::OP_LOWSQ:
            begin
                mul_x = $signed({1'b0, low_reg});
                mul_y = $signed({1'b0, low_reg});
            end
            imusbc_pkg::OP_HIGHSQ:
            begin
                mul_x = $signed({1'b0, high_reg});
                mul_y = $signed({1'b0, high_reg});
            end
            imusbc_pkg::OP_XZ:
            begin
                mul_x = 32'(a_reg[1]);
                mul_y = 32'(a_reg[3]);
            end
            imusbc_pkg::OP_WY:
            begin
                mul_x = 32'(a_reg[0]);
                mul_y = 32'(a_reg[2]);
            end
            imusbc_pkg::OP_YZ:
            begin
                mul_x = 32'(a_reg[2]);
                mul_y = 32'(a_reg[3]);
            end
            imusbc_pkg::OP_WX:
            begin
                mul_x = 32'(a_reg[0]);
                mul_y = 32'(a_reg[1]);
            end
            imusbc_pkg::OP_XX:
            begin
                mul_x = 32'(a_reg[1]);
                mul_y = 32'(a_reg[1]);
            end
            imusbc_pkg::OP_YY:
            begin
                mul_x = 32'(a_reg[2]);
                mul_y = 32'(a_reg[2]);
            end
            [imusbc_pkg::OP_GT0:imusbc_pkg::OP_GT2]:
            begin
                k     = 2'(op_reg - imusbc_pkg::OP_GT0);
                mul_x = $signed({1'b0, grav_reg});
                mul_y = t_reg[k][31:0];
            end
            default:
            begin
                mul_x = 32'sd0;
                mul_y = 32'sd0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imusbc_pkg::ST_IDLE:
                if (s_axis_tvalid)
                    state_next = phase_skip ? imusbc_pkg::ST_IDLE : imusbc_pkg::ST_MUL;
            imusbc_pkg::ST_MUL:
                state_next = imusbc_pkg::ST_ACC;
            imusbc_pkg::ST_ACC:
                if (op_reg == imusbc_pkg::OP_QSQ_LAST)
                    state_next = imusbc_pkg::ST_QCHK;
                else if (op_reg == imusbc_pkg::OP_HIGHSQ)
                    state_next = imusbc_pkg::ST_STILL_CHK;
                else if (op_reg == imusbc_pkg::OP_GT2)
                    state_next = imusbc_pkg::ST_SUM;
                else
                    state_next = imusbc_pkg::ST_MUL;
            imusbc_pkg::ST_QCHK:
                state_next = q_small ? imusbc_pkg::ST_IDLE : imusbc_pkg::ST_SQRT;
            imusbc_pkg::ST_SQRT:
                if (sq_last)
                    state_next = imusbc_pkg::ST_QDIV;
            imusbc_pkg::ST_QDIV:
                if (div_last && idx_reg == 3'd3)
                    state_next = calibrated_reg ? imusbc_pkg::ST_EMIT : imusbc_pkg::ST_MUL;
            imusbc_pkg::ST_STILL_CHK:
                state_next = still_fail ? imusbc_pkg::ST_IDLE : imusbc_pkg::ST_MUL;
            imusbc_pkg::ST_SUM:
                if (idx_reg == 3'd5)
                    state_next = imusbc_pkg::ST_COUNT;
            imusbc_pkg::ST_COUNT:
                state_next = count_short ? imusbc_pkg::ST_IDLE : imusbc_pkg::ST_BIAS;
            imusbc_pkg::ST_BIAS:
                if (div_last && idx_reg == 3'd5)
                    state_next = imusbc_pkg::ST_IDLE;
            imusbc_pkg::ST_EMIT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = imusbc_pkg::ST_IDLE;
            default:
                state_next = imusbc_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        logic               div_load;
        logic [2:0]         load_idx;
        logic [63:0]        pmag;
        logic [35:0]        rmag;
        logic signed [35:0] tv;
        logic signed [49:0] ssum;
        logic signed [36:0] resid;
        logic [47:0]        smag;
        logic signed [17:0] qa;
        logic signed [32:0] diff;
        logic [31:0]        sat_o [6];
        logic [1:0]         k;
        logic [2:0]         bi;

        div_load = 1'b0;
        load_idx = 3'd0;
        pmag     = 64'd0;
        rmag     = 36'd0;
        tv       = 36'sd0;
        ssum     = 50'sd0;
        resid    = 37'sd0;
        smag     = 48'd0;
        qa       = 18'sd0;
        diff     = 33'sd0;
        k        = 2'd0;
        bi       = 3'd0;
        for (int i = 0; i < 6; i++)
            sat_o[i] = 32'd0;

        q_next          = q_reg;
        gy_next         = gy_reg;
        ac_next         = ac_reg;
        grav_next       = grav_reg;
        lim_next        = lim_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        samples_next    = samples_reg;
        calibrated_next = calibrated_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        bias_next       = bias_reg;
        op_next         = op_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        an_next         = an_reg;
        limsq_next      = limsq_reg;
        lowsq_next      = lowsq_reg;
        highsq_next     = highsq_reg;
        x_next          = x_reg;
        r_next          = r_reg;
        sq_cnt_next     = sq_cnt_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        div_cnt_next    = div_cnt_reg;
        idx_next        = idx_reg;
        a_next          = a_reg;
        t_next          = t_reg;
        e_next          = e_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                imusbc_pkg::CFG_GRAVITY:  grav_next    = cfg_wdata;
                imusbc_pkg::CFG_RATE_LIM: lim_next     = cfg_wdata;
                imusbc_pkg::CFG_ACC_LOW:  low_next     = cfg_wdata;
                imusbc_pkg::CFG_ACC_HIGH: high_next    = cfg_wdata;
                imusbc_pkg::CFG_SAMPLES:  samples_next = cfg_wdata[15:0];
                default:                  ;
            endcase
        end

        case (state_reg)
            imusbc_pkg::ST_IDLE:
                if (s_axis_tvalid)
                begin
                    for (int i = 0; i < 4; i++)
                        q_next[i] = s_axis_tdata[16*i +: 16];
                    for (int i = 0; i < 3; i++)
                    begin
                        gy_next[i] = s_axis_tdata[64 + 32*i +: 32];
                        ac_next[i] = s_axis_tdata[160 + 32*i +: 32];
                    end
                    if (calibrated_reg)
                        phase_next = phase_skip ? phase_inc[PHASE_W-1:0] : '0;
                    op_next = imusbc_pkg::OP_QSQ0;
                end
            imusbc_pkg::ST_MUL:
                prod_next = mul_x * mul_y;
            imusbc_pkg::ST_ACC:
            begin
                op_next = op_reg + 5'd1;
                case (op_reg) inside
                    [imusbc_pkg::OP_QSQ0:imusbc_pkg::OP_QSQ_LAST]:
                        acc_next = ((op_reg == imusbc_pkg::OP_QSQ0) ? 64'd0 : acc_reg)
                                   + $unsigned(prod_reg);
                    [imusbc_pkg::OP_GYSQ0:imusbc_pkg::OP_GYSQ2]:
                        acc_next = ((op_reg == imusbc_pkg::OP_GYSQ0) ? 64'd0 : acc_reg)
                                   + $unsigned(prod_reg);
                    imusbc_pkg::OP_LIMSQ:
                        limsq_next = prod_reg[61:0];
                    [imusbc_pkg::OP_ACSQ0:imusbc_pkg::OP_ACSQ2]:
                        an_next = ((op_reg == imusbc_pkg::OP_ACSQ0) ? 64'd0 : an_reg)
                                  + $unsigned(prod_reg);
                    imusbc_pkg::OP_LOWSQ:
                        lowsq_next = prod_reg[61:0];
                    imusbc_pkg::OP_HIGHSQ:
                        highsq_next = prod_reg[61:0];
                    imusbc_pkg::OP_XZ:
                        t_next[0] = prod_reg[35:0];
                    imusbc_pkg::OP_WY:
                    begin
                        tv        = t_reg[0] - prod_reg[35:0];
                        t_next[0] = tv <<< 1;
                    end
                    imusbc_pkg::OP_YZ:
                        t_next[1] = prod_reg[35:0];
                    imusbc_pkg::OP_WX:
                    begin
                        tv        = t_reg[1] + prod_reg[35:0];
                        t_next[1] = tv <<< 1;
                    end
                    imusbc_pkg::OP_XX:
                        t_next[2] = prod_reg[35:0];
                    imusbc_pkg::OP_YY:
                    begin
                        tv        = t_reg[2] + prod_reg[35:0];
                        t_next[2] = 36'sd268435456 - (tv <<< 1);
                    end
                    [imusbc_pkg::OP_GT0:imusbc_pkg::OP_GT2]:
                    begin
                        k    = 2'(op_reg - imusbc_pkg::OP_GT0);
                        pmag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
                        rmag = 36'((pmag + 64'd134217728) >> 28);
                        e_next[k] = prod_reg[63] ? -$signed(rmag) : $signed(rmag);
                    end
                    default: ;
                endcase
                if (op_reg == imusbc_pkg::OP_GT2)
                    idx_next = 3'd0;
            end
            imusbc_pkg::ST_QCHK:
            begin
                x_next      = acc_reg << 28;
                r_next      = 64'd0;
                sq_cnt_next = 5'd31;
            end
            imusbc_pkg::ST_SQRT:
            begin
                if (sq_ge)
                begin
                    x_next = x_reg - sq_tr;
                    r_next = (r_reg >> 1) + sq_bit;
                end
                else
                    r_next = r_reg >> 1;
                sq_cnt_next = sq_cnt_reg - 5'd1;
                if (sq_last)
                begin
                    n_next   = r_next[30:0];
                    div_load = 1'b1;
                    load_idx = 3'd0;
                end
            end
            imusbc_pkg::ST_QDIV,
            imusbc_pkg::ST_BIAS:
            begin
                rem_next     = div_ge ? 31'(div_trial - {1'b0, div_d}) : div_trial[30:0];
                dvd_next     = quo_final;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_last)
                begin
                    if (state_reg == imusbc_pkg::ST_QDIV)
                    begin
                        k  = idx_reg[1:0];
                        qa = $signed({1'b0, quo_final[16:0]});
                        a_next[k] = q_reg[k][15] ? -qa : qa;
                        if (idx_reg != 3'd3)
                        begin
                            div_load = 1'b1;
                            load_idx = idx_reg + 3'd1;
                        end
                        else
                            op_next = imusbc_pkg::OP_GYSQ0;
                    end
                    else
                    begin
                        if (sum_reg[idx_reg][47])
                            bias_next[idx_reg] = (quo_final > 49'd2147483648)
                                ? 32'sh80000000 : 32'(-$signed({1'b0, quo_final[31:0]}));
                        else
                            bias_next[idx_reg] = (quo_final > 49'd2147483647)
                                ? 32'sh7fffffff : $signed(quo_final[31:0]);
                        if (idx_reg != 3'd5)
                        begin
                            div_load = 1'b1;
                            load_idx = idx_reg + 3'd1;
                        end
                        else
                        begin
                            calibrated_next = 1'b1;
                            phase_next      = '0;
                        end
                    end
                end
            end
            imusbc_pkg::ST_STILL_CHK:
                op_next = imusbc_pkg::OP_XZ;
            imusbc_pkg::ST_SUM:
            begin
                if (idx_reg < 3'd3)
                begin
                    k     = idx_reg[1:0];
                    resid = 37'(ac_reg[k]) - 37'(e_reg[k]);
                    ssum  = 50'(sum_reg[idx_reg]) + 50'(resid);
                end
                else
                begin
                    k    = 2'(idx_reg - 3'd3);
                    ssum = 50'(sum_reg[idx_reg]) + 50'(gy_reg[k]);
                end
                if (ssum > SUM_MAX)
                    sum_next[idx_reg] = SUM_MAX[47:0];
                else if (ssum < SUM_MIN)
                    sum_next[idx_reg] = SUM_MIN[47:0];
                else
                    sum_next[idx_reg] = ssum[47:0];
                idx_next = idx_reg + 3'd1;
            end
            imusbc_pkg::ST_COUNT:
            begin
                count_next = count_inc;
                if (!count_short)
                begin
                    div_load = 1'b1;
                    load_idx = 3'd0;
                end
            end
            imusbc_pkg::ST_EMIT:
                if (!out_valid_reg || m_axis_tready)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        bi = 3'(i);
                        if (i < 3)
                            diff = 33'(gy_reg[i % 3]) - 33'(bias_reg[bi + 3'd3]);
                        else
                            diff = 33'(ac_reg[i % 3]) - 33'(bias_reg[bi - 3'd3]);
                        if (diff > 33'sd2147483647)
                            sat_o[i] = 32'h7fffffff;
                        else if (diff < -33'sd2147483648)
                            sat_o[i] = 32'h80000000;
                        else
                            sat_o[i] = diff[31:0];
                    end
                    for (int i = 0; i < 4; i++)
                        out_data_next[16*i +: 16] = a_reg[i][15:0];
                    for (int i = 0; i < 6; i++)
                        out_data_next[64 + 32*i +: 32] = sat_o[i];
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase

        // divider operand load, quaternion or bias
        if (div_load)
        begin
            idx_next     = load_idx;
            div_cnt_next = 6'd0;
            rem_next     = 31'd0;
            if (state_reg == imusbc_pkg::ST_SQRT || state_reg == imusbc_pkg::ST_QDIV)
            begin
                k        = load_idx[1:0];
                smag     = q_reg[k][15] ? 48'(-33'(q_reg[k])) : 48'(q_reg[k]);
                dvd_next = 49'(smag << 28) + 49'(n_next[30:1]);
            end
            else
            begin
                smag     = sum_reg[load_idx][47] ? 48'(-sum_reg[load_idx])
                                                 : 48'(sum_reg[load_idx]);
                dvd_next = 49'(smag) + 49'(count_next[15:1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= imusbc_pkg::ST_IDLE;
            grav_reg       <= 31'd619993;
            lim_reg        <= 31'd6554;
            low_reg        <= 31'd524288;
            high_reg       <= 31'd720896;
            samples_reg    <= 16'd1000;
            calibrated_reg <= 1'b0;
            phase_reg      <= '0;
            count_reg      <= 16'd0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                sum_reg[i]  <= 48'sd0;
                bias_reg[i] <= 32'sd0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            grav_reg       <= grav_next;
            lim_reg        <= lim_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            samples_reg    <= samples_next;
            calibrated_reg <= calibrated_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            sum_reg        <= sum_next;
            bias_reg       <= bias_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        gy_reg       <= gy_next;
        ac_reg       <= ac_next;
        op_reg       <= op_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        an_reg       <= an_next;
        limsq_reg    <= limsq_next;
        lowsq_reg    <= lowsq_next;
        highsq_reg   <= highsq_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        sq_cnt_reg   <= sq_cnt_next;
        n_reg        <= n_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        div_cnt_reg  <= div_cnt_next;
        idx_reg      <= idx_next;
        a_reg        <= a_next;
        t_reg        <= t_next;
        e_reg        <= e_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_NEXT(a_calib_sticky, clk, rst_n, calibrated_reg, calibrated_reg)
    `ASSERT_SAME(a_emit_calib, clk, rst_n, state_reg == imusbc_pkg::ST_EMIT, calibrated_reg)
    `ASSERT_SAME(a_phase_range, clk, rst_n, 1'b1, {1'b0, phase_reg} < DEC_C)
    `ASSERT_SAME(a_count_step, clk, rst_n, count_reg != $past(count_reg), count_reg == 16'($past(count_reg) + 16'd1) && !calibrated_reg)

endmodule
